// File: hdl/pdbv_pkg.sv
// Package for the pose difference body velocity unit.
// Holds the sequencer state type and the fixed widths and constants; no dependencies.
`default_nettype none

package pdbv_pkg;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int VEL_W   = 32;
    localparam int DIFF_W  = POS_W + 1;    // position difference
    localparam int QPROD_W = 2 * QUAT_W;   // product of two quaternion parts
    localparam int CSUM_W  = QPROD_W + 3;  // sum of four products, doubled
    localparam int COEF_W  = 29;           // rotation coefficient in Q.24
    localparam int COEF_SH = 2 * (QUAT_W - 1) - 24;
    localparam int MA_W    = 29;           // multiplier operand A
    localparam int MB_W    = 18;           // multiplier operand B
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 64;
    localparam int ROT_W   = 44;           // rotated difference in Q.20
    localparam int ROT_LO  = 28;           // low part width of the rotated value
    localparam int CNT_W   = 6;            // divider step counter
    localparam int NUM_QP  = 10;           // quaternion products
    localparam int NUM_M   = 9;            // matrix coefficients

    localparam logic [MB_W-1:0] SCALE_US = MB_W'(62500);

    // Quaternion product slots.
    localparam logic [3:0] QP_WW = 4'd0;
    localparam logic [3:0] QP_XX = 4'd1;
    localparam logic [3:0] QP_YY = 4'd2;
    localparam logic [3:0] QP_ZZ = 4'd3;
    localparam logic [3:0] QP_XY = 4'd4;
    localparam logic [3:0] QP_WZ = 4'd5;
    localparam logic [3:0] QP_XZ = 4'd6;
    localparam logic [3:0] QP_WY = 4'd7;
    localparam logic [3:0] QP_YZ = 4'd8;
    localparam logic [3:0] QP_WX = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_QSTORE,
        ST_COEF,
        ST_MUL,
        ST_ACC,
        ST_ROUND,
        ST_SMUL,
        ST_SACC,
        ST_DIVINIT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/pose_difference_body_velocity_unit.sv
// Top level of the pose difference body velocity unit: sequencer and shared datapath.
// Depends on pdbv_pkg for the state type and fixed widths.
`default_nettype none

//  Channel | Handshake                    | Payload
//  --------+------------------------------+-------------------------------------------
//  input   | i_in_valid / o_in_stall      | i_stamp_us, i_pos_x/y/z, i_quat_w/x/y/z
//  output  | o_out_valid / i_out_stall    | o_vel_x/y/z, o_time_error
//
// An item that follows a previous sample keeps the input stalled until it is through:
// the ten quaternion products, the nine rotation coefficients, and for each of the
// three axes the matrix row, rounding and scaling and the divider; then it hands the
// result over, waiting while the output is stalled, and goes back to idle.
// The steps share the one 29 by 18 bit multiplier; the divider is bit-serial.
// The first item after reset is only stored; a zero time difference skips the steps.
// Reset is synchronous and active low. The output register holds a result until it
// is taken; a new item is accepted meanwhile, but its result waits in the sequencer.

module pose_difference_body_velocity_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [pdbv_pkg::TIME_W-1:0]         i_stamp_us,
    input  wire  signed [pdbv_pkg::POS_W-1:0]   i_pos_x,
    input  wire  signed [pdbv_pkg::POS_W-1:0]   i_pos_y,
    input  wire  signed [pdbv_pkg::POS_W-1:0]   i_pos_z,
    input  wire  signed [pdbv_pkg::QUAT_W-1:0]  i_quat_w,
    input  wire  signed [pdbv_pkg::QUAT_W-1:0]  i_quat_x,
    input  wire  signed [pdbv_pkg::QUAT_W-1:0]  i_quat_y,
    input  wire  signed [pdbv_pkg::QUAT_W-1:0]  i_quat_z,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [pdbv_pkg::VEL_W-1:0]   o_vel_x,
    output logic signed [pdbv_pkg::VEL_W-1:0]   o_vel_y,
    output logic signed [pdbv_pkg::VEL_W-1:0]   o_vel_z,
    output logic                                o_time_error
);
    import pdbv_pkg::*;

    // Sequencer.
    t_state r_state, n_state;

    // Stored previous sample.
    logic                     r_have_prev;
    logic [TIME_W-1:0]        r_prev_stamp;
    logic signed [POS_W-1:0]  r_prev_x, r_prev_y, r_prev_z;
    logic signed [QUAT_W-1:0] r_prev_qw, r_prev_qx, r_prev_qy, r_prev_qz;

    // Working copy of the item under way: the quaternion of the earlier sample,
    // the position difference and the time difference.
    logic signed [QUAT_W-1:0] r_cw, r_cx, r_cy, r_cz;
    logic signed [DIFF_W-1:0] r_d [3];
    logic [TIME_W-1:0]        r_dt;

    // Intermediate results.
    logic signed [QPROD_W-1:0] r_qp [NUM_QP];
    logic signed [COEF_W-1:0]  r_m  [NUM_M];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ROT_W-1:0]   r_rot;
    logic [ACC_W-1:0]          r_quo;
    logic [TIME_W:0]           r_rem;
    logic                      r_neg;
    logic signed [VEL_W-1:0]   r_vel [3];
    logic                      r_err;

    // Counters: product or coefficient slot, axis, column, half and divider step.
    logic [3:0]       r_k;
    logic [1:0]       r_i;
    logic [1:0]       r_j;
    logic             r_half;
    logic [CNT_W-1:0] r_cnt;

    logic                     accept;
    logic                     out_free;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [TIME_W:0]   dt_full;
    logic [TIME_W-1:0]        dt_new;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign dt_new   = i_stamp_us - r_prev_stamp;
    assign dt_full  = {1'b0, r_dt};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && r_have_prev) begin
                    n_state = (dt_new == '0) ? ST_DONE : ST_QMUL;
                end
            end
            ST_QMUL:    n_state = ST_QSTORE;
            ST_QSTORE:  n_state = (r_k == 4'(NUM_QP - 1)) ? ST_COEF : ST_QMUL;
            ST_COEF:    n_state = (r_k == 4'(NUM_M - 1)) ? ST_MUL : ST_COEF;
            ST_MUL:     n_state = ST_ACC;
            ST_ACC:     n_state = (r_half && r_j == 2'd2) ? ST_ROUND : ST_MUL;
            ST_ROUND:   n_state = ST_SMUL;
            ST_SMUL:    n_state = ST_SACC;
            ST_SACC:    n_state = r_half ? ST_DIVINIT : ST_SMUL;
            ST_DIVINIT: n_state = ST_DIV;
            ST_DIV:     n_state = (r_cnt == '1) ? ST_FIN : ST_DIV;
            ST_FIN:     n_state = (r_i == 2'd2) ? ST_DONE : ST_MUL;
            ST_DONE:    n_state = out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input stall and the operands of the shared multiplier.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            ST_QMUL: begin
                unique case (r_k)
                    QP_WW:   begin mul_a = MA_W'(r_cw); mul_b = MB_W'(r_cw); end
                    QP_XX:   begin mul_a = MA_W'(r_cx); mul_b = MB_W'(r_cx); end
                    QP_YY:   begin mul_a = MA_W'(r_cy); mul_b = MB_W'(r_cy); end
                    QP_ZZ:   begin mul_a = MA_W'(r_cz); mul_b = MB_W'(r_cz); end
                    QP_XY:   begin mul_a = MA_W'(r_cx); mul_b = MB_W'(r_cy); end
                    QP_WZ:   begin mul_a = MA_W'(r_cw); mul_b = MB_W'(r_cz); end
                    QP_XZ:   begin mul_a = MA_W'(r_cx); mul_b = MB_W'(r_cz); end
                    QP_WY:   begin mul_a = MA_W'(r_cw); mul_b = MB_W'(r_cy); end
                    QP_YZ:   begin mul_a = MA_W'(r_cy); mul_b = MB_W'(r_cz); end
                    QP_WX:   begin mul_a = MA_W'(r_cw); mul_b = MB_W'(r_cx); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_MUL: begin
                mul_a = r_m[r_k];
                if (r_half) begin
                    mul_b = MB_W'($signed(r_d[r_j][DIFF_W-1:16]));
                end else begin
                    mul_b = {2'b00, r_d[r_j][15:0]};
                end
            end
            ST_SMUL: begin
                if (r_half) begin
                    mul_a = MA_W'($signed(r_rot[ROT_W-1:ROT_LO]));
                end else begin
                    mul_a = {1'b0, r_rot[ROT_LO-1:0]};
                end
                mul_b = SCALE_US;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Coefficient formation for slot r_k: a sum of products, then rounded to Q.24.
    logic signed [CSUM_W-1:0] csum;
    logic [CSUM_W-1:0]        cmag;
    logic [CSUM_W-1:0]        crnd;
    logic signed [COEF_W-1:0] coef;

    always_comb begin
        unique case (r_k)
            4'd0: csum = CSUM_W'(r_qp[QP_WW]) + CSUM_W'(r_qp[QP_XX])
                         - CSUM_W'(r_qp[QP_YY]) - CSUM_W'(r_qp[QP_ZZ]);
            4'd1: csum = (CSUM_W'(r_qp[QP_XY]) + CSUM_W'(r_qp[QP_WZ])) <<< 1;
            4'd2: csum = (CSUM_W'(r_qp[QP_XZ]) - CSUM_W'(r_qp[QP_WY])) <<< 1;
            4'd3: csum = (CSUM_W'(r_qp[QP_XY]) - CSUM_W'(r_qp[QP_WZ])) <<< 1;
            4'd4: csum = CSUM_W'(r_qp[QP_WW]) - CSUM_W'(r_qp[QP_XX])
                         + CSUM_W'(r_qp[QP_YY]) - CSUM_W'(r_qp[QP_ZZ]);
            4'd5: csum = (CSUM_W'(r_qp[QP_YZ]) + CSUM_W'(r_qp[QP_WX])) <<< 1;
            4'd6: csum = (CSUM_W'(r_qp[QP_XZ]) + CSUM_W'(r_qp[QP_WY])) <<< 1;
            4'd7: csum = (CSUM_W'(r_qp[QP_YZ]) - CSUM_W'(r_qp[QP_WX])) <<< 1;
            4'd8: csum = CSUM_W'(r_qp[QP_WW]) - CSUM_W'(r_qp[QP_XX])
                         - CSUM_W'(r_qp[QP_YY]) + CSUM_W'(r_qp[QP_ZZ]);
            default: csum = '0;
        endcase
        // Round half away from zero on the magnitude.
        cmag = csum[CSUM_W-1] ? CSUM_W'(-csum) : CSUM_W'(csum);
        crnd = (cmag + (CSUM_W'(1) << (COEF_SH - 1))) >> COEF_SH;
        coef = csum[CSUM_W-1] ? -COEF_W'(crnd) : COEF_W'(crnd);
    end

    // Rounding of the accumulated row from Q.40 to Q.20.
    logic [ACC_W-1:0] amag;
    logic [ACC_W-1:0] arnd;
    assign amag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign arnd = (amag + (ACC_W'(1) << 19)) >> 20;

    // One restoring divider step: shift in the next numerator bit and try the subtraction.
    logic [TIME_W:0] div_try;
    logic            div_ge;
    assign div_try = {r_rem[TIME_W-1:0], r_quo[ACC_W-1]};
    assign div_ge  = (div_try >= dt_full);

    // Final rounding of the quotient and saturation to the velocity range.
    logic [TIME_W:0]         rem_left;
    logic [ACC_W-1:0]        qrnd;
    logic signed [VEL_W-1:0] vel_fin;
    always_comb begin
        rem_left = dt_full - r_rem;
        qrnd     = (r_rem >= rem_left) ? r_quo + ACC_W'(1) : r_quo;
        if (!r_neg && qrnd > ACC_W'(32'h7FFF_FFFF)) begin
            vel_fin = {1'b0, {(VEL_W-1){1'b1}}};
        end else if (r_neg && qrnd > ACC_W'(33'h0_8000_0000)) begin
            vel_fin = {1'b1, {(VEL_W-1){1'b0}}};
        end else if (r_neg) begin
            vel_fin = -VEL_W'(qrnd);
        end else begin
            vel_fin = VEL_W'(qrnd);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_prev <= 1'b0;
            o_out_valid <= 1'b0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_half      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_have_prev <= 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_k    <= '0;
                    r_i    <= '0;
                    r_j    <= '0;
                    r_half <= 1'b0;
                end
                ST_QSTORE: begin
                    r_k <= (r_k == 4'(NUM_QP - 1)) ? '0 : r_k + 4'd1;
                end
                ST_COEF: begin
                    r_k <= (r_k == 4'(NUM_M - 1)) ? '0 : r_k + 4'd1;
                end
                ST_ACC: begin
                    r_half <= !r_half;
                    if (r_half) begin
                        r_k <= r_k + 4'd1;
                        r_j <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                    end
                end
                ST_SACC: begin
                    r_half <= !r_half;
                end
                ST_DIVINIT: begin
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                ST_FIN: begin
                    r_i <= r_i + 2'd1;
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (accept) begin
            r_prev_stamp <= i_stamp_us;
            r_prev_x     <= i_pos_x;
            r_prev_y     <= i_pos_y;
            r_prev_z     <= i_pos_z;
            r_prev_qw    <= i_quat_w;
            r_prev_qx    <= i_quat_x;
            r_prev_qy    <= i_quat_y;
            r_prev_qz    <= i_quat_z;
            // The rotation uses the orientation of the earlier sample.
            r_cw   <= r_prev_qw;
            r_cx   <= r_prev_qx;
            r_cy   <= r_prev_qy;
            r_cz   <= r_prev_qz;
            r_d[0] <= DIFF_W'(i_pos_x) - DIFF_W'(r_prev_x);
            r_d[1] <= DIFF_W'(i_pos_y) - DIFF_W'(r_prev_y);
            r_d[2] <= DIFF_W'(i_pos_z) - DIFF_W'(r_prev_z);
            r_dt   <= dt_new;
            r_acc  <= '0;
            // A zero time difference gives a zero velocity and the error flag.
            r_err    <= (dt_new == '0);
            r_vel[0] <= '0;
            r_vel[1] <= '0;
            r_vel[2] <= '0;
        end

        unique case (r_state)
            ST_QSTORE: r_qp[r_k] <= QPROD_W'(r_prod);
            ST_COEF:   r_m[r_k]  <= coef;
            ST_ACC: begin
                if (r_half) begin
                    r_acc <= r_acc + (ACC_W'(r_prod) <<< 16);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            ST_ROUND: begin
                r_rot <= r_acc[ACC_W-1] ? -ROT_W'(arnd) : ROT_W'(arnd);
                r_acc <= '0;
            end
            ST_SACC: begin
                if (r_half) begin
                    r_acc <= r_acc + (ACC_W'(r_prod) <<< ROT_LO);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            ST_DIVINIT: begin
                r_neg <= r_acc[ACC_W-1];
                r_quo <= amag;
                r_rem <= '0;
            end
            ST_DIV: begin
                r_rem <= div_ge ? div_try - dt_full : div_try;
                r_quo <= {r_quo[ACC_W-2:0], div_ge};
            end
            ST_FIN: begin
                r_vel[r_i] <= vel_fin;
                r_acc      <= '0;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase

        if (r_state == ST_DONE && out_free) begin
            o_vel_x      <= r_vel[0];
            o_vel_y      <= r_vel[1];
            o_vel_z      <= r_vel[2];
            o_time_error <= r_err;
        end
    end

endmodule

`default_nettype wire
